[rtl/core/emst_pkg.sv]
// ----------------------------------------------------------------------------
// emst_pkg
// shared widths, defaults and sequencer states of the extent map translator
// ----------------------------------------------------------------------------
`default_nettype none

package emst_pkg;

   // default sizing of the translator
   localparam int DEF_MAX_ENTRIES        = 64;
   localparam int DEF_SECTORS_PER_BLOCK  = 4;
   localparam int DEF_MAX_REQUEST_BLOCKS = 64;

   // fixed field widths
   localparam int ENTRY_COUNT_W  = 7;
   localparam int ENTRY_INDEX_W  = 6;
   localparam int ENTRY_START_W  = 32;
   localparam int ENTRY_LENGTH_W = 31;
   localparam int ENTRY_OFFSET_W = 40;
   localparam int REQ_BLOCK_W    = 32;
   localparam int REQ_COUNT_W    = 7;
   localparam int PHYS_W         = 41;
   localparam int SECTOR_COUNT_W = 9;

   // packed request and response payloads
   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 56;

   // request kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CACHE,
      ST_SCAN,
      ST_REL,
      ST_PHYS,
      ST_CLIP,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

[rtl/core/emst_ram.sv]
// ----------------------------------------------------------------------------
// emst_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module emst_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/extent_map_sector_translator_core.sv]
// ----------------------------------------------------------------------------
// extent_map_sector_translator_core
// translates logical block reads into physical sectors through an extent table
// ----------------------------------------------------------------------------
//
//  channel  dir   handshake                 payload
//  req_*    in    req_tvalid / req_tready    tdata: entry fields + read fields, tuser: kind
//  rsp_*    out   rsp_tvalid / rsp_tready    tdata: physical sector + count, tuser: found
//  csr_*    in    csr_valid / csr_ready      csr_data: entry_count
//
//  a load is written to the table when it is accepted; a read that hits the cached extent steps
//  through the cache, rel, phys, clip and resp states, with a scan over the table entries between
//  cache and rel on a miss (up to MAX_ENTRIES); a read that finds nothing goes from cache or scan to resp
//  reset clears entry_count, cached hit index, sequencer and response valid, not the table
//  a stalled response waits in its output register; the next request is taken
//  and holds in its last step until the register frees up
//
`default_nettype none

module extent_map_sector_translator_core
   import emst_pkg::*;
#(
   parameter int MAX_ENTRIES        = DEF_MAX_ENTRIES,
   parameter int SECTORS_PER_BLOCK  = DEF_SECTORS_PER_BLOCK,
   parameter int MAX_REQUEST_BLOCKS = DEF_MAX_REQUEST_BLOCKS
) (
   input  logic                     clock,
   input  logic                     reset,

   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [5:0] entry_index, [37:6] entry_start, [68:38] entry_length,
   // [108:69] entry_offset, [140:109] request_block, [147:141] request_count
   input  logic [REQ_DATA_W-1:0]    req_tdata,
   // [0] kind
   input  logic                     req_tuser,

   // response channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [40:0] physical_sector, [49:41] sector_count
   output logic [RSP_DATA_W-1:0]    rsp_tdata,
   // [0] found
   output logic                     rsp_tuser,

   // entry_count register write
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [ENTRY_COUNT_W-1:0] csr_data
);

   // table index and limit widths
   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int LIM_W  = $clog2(MAX_ENTRIES + 1);
   localparam int LC_W   = (LIM_W > ENTRY_COUNT_W) ? LIM_W : ENTRY_COUNT_W;
   localparam int SLOT_W = (IDX_W > ENTRY_INDEX_W) ? IDX_W : ENTRY_INDEX_W;
   // request count saturation and sector demand widths
   localparam int BLK_W  = $clog2(MAX_REQUEST_BLOCKS + 1);
   localparam int CNT_W  = (BLK_W > REQ_COUNT_W) ? BLK_W : REQ_COUNT_W;
   localparam int WANT_W = $clog2(MAX_REQUEST_BLOCKS * SECTORS_PER_BLOCK + 1);
   localparam int CLIP_W = (WANT_W > ENTRY_LENGTH_W) ? WANT_W : ENTRY_LENGTH_W;

   // one table word: end of extent kept instead of length, so a lookup is two compares
   typedef struct packed {
      logic [PHYS_W-1:0]         ext_end;
      logic [ENTRY_OFFSET_W-1:0] ext_off;
      logic [ENTRY_START_W-1:0]  ext_start;
   } extent_type;

   localparam int EXT_W = $bits(extent_type);

   // request payload fields
   logic [ENTRY_INDEX_W-1:0]  f_index;
   logic [ENTRY_START_W-1:0]  f_start;
   logic [ENTRY_LENGTH_W-1:0] f_length;
   logic [ENTRY_OFFSET_W-1:0] f_offset;
   logic [REQ_BLOCK_W-1:0]    f_block;
   logic [REQ_COUNT_W-1:0]    f_count;

   assign f_index  = req_tdata[5:0];
   assign f_start  = req_tdata[37:6];
   assign f_length = req_tdata[68:38];
   assign f_offset = req_tdata[108:69];
   assign f_block  = req_tdata[140:109];
   assign f_count  = req_tdata[147:141];

   // registers
   state_type                 state_ff, state_in;
   logic [ENTRY_COUNT_W-1:0]  entry_count_ff;
   logic [IDX_W-1:0]          last_hit_ff, last_hit_in;
   logic [IDX_W-1:0]          chk_ff, chk_in;
   logic [PHYS_W-1:0]         pos_ff, pos_in;
   logic [WANT_W-1:0]         want_ff, want_in;
   extent_type                ent_ff, ent_in;
   logic [PHYS_W-1:0]         rel_ff, rel_in;
   logic [PHYS_W-1:0]         left_ff, left_in;
   logic [PHYS_W-1:0]         phys_ff, phys_in;
   logic [SECTOR_COUNT_W-1:0] cnt_ff, cnt_in;
   logic                      found_ff, found_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [PHYS_W-1:0]         rsp_phys_ff, rsp_phys_in;
   logic [SECTOR_COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   // extent ram ports
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   extent_type        ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   logic [EXT_W-1:0]  ram_rdata;
   extent_type        rd_ext;

   // helpers
   logic                  req_fire;
   logic [LIM_W-1:0]      limit;
   logic [LC_W-1:0]       ec_ext;
   logic [SLOT_W-1:0]     slot_ext;
   logic                  slot_ok;
   logic [CNT_W-1:0]      cnt_ext;
   logic [BLK_W-1:0]      blocks;
   logic                  rd_holds;
   logic                  cache_ok;
   logic [LIM_W-1:0]      nxt_cnt;
   logic [CLIP_W-1:0]     want_ext;
   logic [CLIP_W-1:0]     left_ext;
   logic                  rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // entries scanned: entry_count capped at table depth
   assign ec_ext = LC_W'(entry_count_ff);
   assign limit  = (ec_ext > LC_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES) : LIM_W'(ec_ext);

   // load slot check, slots past the table are dropped
   assign slot_ext = SLOT_W'(f_index);
   assign slot_ok  = (32'(slot_ext) < 32'(MAX_ENTRIES));

   // block count saturation
   assign cnt_ext = CNT_W'(f_count);
   assign blocks  = (cnt_ext > CNT_W'(MAX_REQUEST_BLOCKS)) ?
                    BLK_W'(MAX_REQUEST_BLOCKS) : BLK_W'(cnt_ext);

   // shared lookup compare on whatever word the ram presents
   assign rd_ext   = extent_type'(ram_rdata);
   assign rd_holds = (PHYS_W'(rd_ext.ext_off) <= pos_ff) && (pos_ff < rd_ext.ext_end);
   assign cache_ok = (LIM_W'(last_hit_ff) < limit);
   assign nxt_cnt  = LIM_W'(chk_ff) + LIM_W'(1);

   assign want_ext = CLIP_W'(want_ff);
   assign left_ext = CLIP_W'(left_ff[ENTRY_LENGTH_W-1:0]);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // load write port
   assign ram_we              = req_fire && (req_tuser == KIND_LOAD) && slot_ok;
   assign ram_waddr           = slot_ext[IDX_W-1:0];
   assign ram_wdata.ext_start = f_start;
   assign ram_wdata.ext_off   = f_offset;
   assign ram_wdata.ext_end   = PHYS_W'(f_offset) + PHYS_W'(f_length);

   emst_ram #(
      .DATA_W (EXT_W),
      .DEPTH  (MAX_ENTRIES)
   ) u_ext_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer: next state, datapath steps and ram read address
   always_comb begin
      state_in     = state_ff;
      last_hit_in  = last_hit_ff;
      chk_in       = chk_ff;
      pos_in       = pos_ff;
      want_in      = want_ff;
      ent_in       = ent_ff;
      rel_in       = rel_ff;
      left_in      = left_ff;
      phys_in      = phys_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_phys_in  = rsp_phys_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      ram_raddr    = last_hit_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // read request: fetch the cached extent first
            if (req_fire && (req_tuser == KIND_READ)) begin
               pos_in   = PHYS_W'(f_block) * PHYS_W'(SECTORS_PER_BLOCK);
               want_in  = WANT_W'(blocks) * WANT_W'(SECTORS_PER_BLOCK);
               state_in = ST_CACHE;
            end
         end
         ST_CACHE: begin
            ram_raddr = '0;
            chk_in    = '0;
            if (cache_ok && rd_holds) begin
               ent_in   = rd_ext;
               state_in = ST_REL;
            end else if (limit == '0) begin
               found_in = 1'b0;
               phys_in  = '0;
               cnt_in   = '0;
               state_in = ST_RESP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // data of entry chk_ff is present, next entry is being fetched
            ram_raddr = chk_ff + IDX_W'(1);
            if (rd_holds) begin
               ent_in      = rd_ext;
               last_hit_in = chk_ff;
               state_in    = ST_REL;
            end else if (nxt_cnt == limit) begin
               found_in = 1'b0;
               phys_in  = '0;
               cnt_in   = '0;
               state_in = ST_RESP;
            end else begin
               chk_in = chk_ff + IDX_W'(1);
            end
         end
         ST_REL: begin
            // sector offset into the extent
            rel_in   = pos_ff - PHYS_W'(ent_ff.ext_off);
            state_in = ST_PHYS;
         end
         ST_PHYS: begin
            phys_in  = PHYS_W'(ent_ff.ext_start) + rel_ff;
            left_in  = ent_ff.ext_end - pos_ff;
            state_in = ST_CLIP;
         end
         ST_CLIP: begin
            // clip demand to sectors left in the extent
            cnt_in   = (want_ext > left_ext) ? SECTOR_COUNT_W'(left_ext) :
                                               SECTOR_COUNT_W'(want_ext);
            found_in = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_phys_in  = phys_ff;
               rsp_cnt_in   = cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         last_hit_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_hit_ff  <= last_hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            entry_count_ff <= csr_data;
         end
      end
   end

   // datapath and response payload
   always_ff @(posedge clock) begin
      chk_ff       <= chk_in;
      pos_ff       <= pos_in;
      want_ff      <= want_in;
      ent_ff       <= ent_in;
      rel_ff       <= rel_in;
      left_ff      <= left_in;
      phys_ff      <= phys_in;
      cnt_ff       <= cnt_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_phys_ff  <= rsp_phys_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {(RSP_DATA_W - PHYS_W - SECTOR_COUNT_W)'(0), rsp_cnt_ff, rsp_phys_ff};

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the extent map sector translator: a short scripted
// pass over the corner cases, then randomized extent tables and read requests
// checked against an in-bench translation of the same table
// ----------------------------------------------------------------------------

module tb
   import emst_pkg::*;
();

   localparam int CLOCK_HALF_NS  = 6;
   localparam int RESET_CYCLES   = 11;
   // worst case of a read: cache probe plus a walk over every table slot
   localparam int SETTLE_CYCLES  = 6 + DEF_MAX_ENTRIES + 10;
   localparam int PHASE_ITEMS    = 100;
   localparam int PHASE_TOTAL    = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int SCRIPT_ROWS    = 24;
   localparam longint TIMEOUT_NS = 10_000_000;

   // one request as the bench sees it, before packing onto req_tdata
   typedef struct packed {
      logic                      kind;
      logic [ENTRY_INDEX_W-1:0]  slot;
      logic [ENTRY_START_W-1:0]  start;
      logic [ENTRY_LENGTH_W-1:0] length;
      logic [ENTRY_OFFSET_W-1:0] offset;
      logic [REQ_BLOCK_W-1:0]    block;
      logic [REQ_COUNT_W-1:0]    count;
   } request_type;

   // one translation result, as carried by rsp_tuser / rsp_tdata
   typedef struct packed {
      logic                      found;
      logic [PHYS_W-1:0]         sector;
      logic [SECTOR_COUNT_W-1:0] sectors;
   } translation_type;

   typedef enum logic [1:0] {
      DO_LOAD,
      DO_READ,
      DO_CSR
   } script_action_type;

   // scripted row: a request, or an entry_count write, with an optional
   // hand-written translation that replaces the computed one
   typedef struct packed {
      script_action_type        action;
      request_type              rq;
      logic [ENTRY_COUNT_W-1:0] csr_value;
      logic                     typed;
      translation_type          want;
   } script_row_type;

   // dut ports
   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata;
   logic                     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [ENTRY_COUNT_W-1:0] csr_data;

   // bench copy of the extent table, the cached hit slot and entry_count
   logic [ENTRY_START_W-1:0]  ext_start [DEF_MAX_ENTRIES];
   logic [ENTRY_LENGTH_W-1:0] ext_len   [DEF_MAX_ENTRIES];
   logic [ENTRY_OFFSET_W-1:0] ext_off   [DEF_MAX_ENTRIES];
   int                        cached_slot;
   int                        entry_count_cfg;

   // translations owed by the dut, oldest first
   translation_type translations_due [$];

   int mismatch_count;
   int sender_idle_pct;
   int receiver_stall_pct;
   bit rsp_hold;

   script_row_type script_rows [SCRIPT_ROWS];
   int             phase_counts [PHASE_TOTAL];

   extent_map_sector_translator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // [5:0] entry_index, [37:6] entry_start, [68:38] entry_length,
      // [108:69] entry_offset, [140:109] request_block, [147:141] request_count
      .req_tdata  (req_tdata),
      // [0] kind
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // [40:0] physical_sector, [49:41] sector_count
      .rsp_tdata  (rsp_tdata),
      // [0] found
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #(CLOCK_HALF_NS) clock = ~clock;

   // ---------------------------------------------------------------------------
   // translation of the bench table
   // ---------------------------------------------------------------------------

   function automatic bit extent_holds(input int idx, input logic [63:0] pos);
      logic [63:0] lo;
      lo = 64'(ext_off[idx]);
      return (lo <= pos) && (pos < lo + 64'(ext_len[idx]));
   endfunction

   // loads update the table; reads give one translation and may move the
   // cached slot (only on a hit)
   task automatic apply_request(input request_type rq, output bit gives,
                                output translation_type tr);
      int          limit;
      int          hit;
      bit          found;
      logic [63:0] pos;
      logic [63:0] rel;
      logic [63:0] left;
      logic [63:0] blocks;
      logic [63:0] want;
      tr    = '0;
      gives = 1'b0;
      found = 1'b0;
      hit   = 0;
      if (rq.kind == KIND_LOAD) begin
         ext_start[rq.slot] = rq.start;
         ext_len[rq.slot]   = rq.length;
         ext_off[rq.slot]   = rq.offset;
      end else begin
         gives = 1'b1;
         limit = (entry_count_cfg < DEF_MAX_ENTRIES) ? entry_count_cfg : DEF_MAX_ENTRIES;
         pos   = 64'(rq.block) * 64'(DEF_SECTORS_PER_BLOCK);
         // the cached slot only counts while it lies below entry_count
         if (cached_slot < limit && extent_holds(cached_slot, pos)) begin
            hit   = cached_slot;
            found = 1'b1;
         end else begin
            for (int i = 0; i < limit && !found; i++) begin
               if (extent_holds(i, pos)) begin
                  hit   = i;
                  found = 1'b1;
               end
            end
         end
         if (found) begin
            cached_slot = hit;
            rel    = pos - 64'(ext_off[hit]);
            left   = 64'(ext_len[hit]) - rel;
            blocks = 64'(rq.count);
            if (blocks > 64'(DEF_MAX_REQUEST_BLOCKS)) blocks = 64'(DEF_MAX_REQUEST_BLOCKS);
            want = blocks * 64'(DEF_SECTORS_PER_BLOCK);
            if (want > left) want = left;
            tr.found   = 1'b1;
            tr.sector  = PHYS_W'(64'(ext_start[hit]) + rel);
            tr.sectors = SECTOR_COUNT_W'(want);
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      // keep the log short when everything goes wrong at once
      if (mismatch_count <= 50)
         $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
   endtask

   // every accepted response is matched against the oldest owed translation
   always @(posedge clock) begin
      translation_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (translations_due.size() == 0) begin
            report_mismatch("response with nothing owed", 64'(rsp_tdata), 64'(0));
         end else begin
            due = translations_due.pop_front();
            if (rsp_tuser !== due.found)
               report_mismatch("found", 64'(rsp_tuser), 64'(due.found));
            if (rsp_tdata[40:0] !== due.sector)
               report_mismatch("physical_sector", 64'(rsp_tdata[40:0]), 64'(due.sector));
            if (rsp_tdata[49:41] !== due.sectors)
               report_mismatch("sector_count", 64'(rsp_tdata[49:41]), 64'(due.sectors));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // drivers; every driver task starts and ends on a falling edge
   // ---------------------------------------------------------------------------

   // response side: random stalls per phase, or a long forced hold-off
   always @(negedge clock) begin
      if (rsp_hold)
         rsp_tready = 1'b0;
      else
         rsp_tready = ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   task automatic send_request(input request_type rq, input bit typed,
                               input translation_type typed_want);
      bit              gives;
      translation_type predicted;
      // random idle cycles ahead of the request
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid          = 1'b1;
      req_tuser           = rq.kind;
      req_tdata           = '0;
      req_tdata[5:0]      = rq.slot;
      req_tdata[37:6]     = rq.start;
      req_tdata[68:38]    = rq.length;
      req_tdata[108:69]   = rq.offset;
      req_tdata[140:109]  = rq.block;
      req_tdata[147:141]  = rq.count;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(rq, gives, predicted);
      if (gives) translations_due.push_back(typed ? typed_want : predicted);
      @(negedge clock);
   endtask

   // entry_count is only written with the request side idle and drained;
   // loads owe nothing, so a settle time covers one still in flight
   task automatic program_entry_count(input logic [ENTRY_COUNT_W-1:0] value);
      req_tvalid = 1'b0;
      while (translations_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      entry_count_cfg = int'(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // every field random, so that the unused half of each request toggles too
   function automatic request_type noise_request();
      request_type rq;
      rq.kind   = KIND_READ;
      rq.slot   = ENTRY_INDEX_W'($urandom);
      rq.start  = $urandom;
      rq.length = ENTRY_LENGTH_W'($urandom);
      rq.offset = {8'($urandom), 32'($urandom)};
      rq.block  = $urandom;
      rq.count  = REQ_COUNT_W'($urandom);
      return rq;
   endfunction

   // extents mostly short and packed into a small window so that they
   // overlap, with a share of huge and empty ones
   function automatic request_type random_extent_load(input int slot);
      request_type rq;
      int          r;
      rq      = noise_request();
      rq.kind = KIND_LOAD;
      rq.slot = ENTRY_INDEX_W'(slot);
      r = $urandom_range(0, 99);
      if (r < 10)      rq.length = '0;
      else if (r < 70) rq.length = ENTRY_LENGTH_W'($urandom_range(1, 3000));
      else             rq.length = ENTRY_LENGTH_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 70)      rq.offset = ENTRY_OFFSET_W'($urandom_range(0, 40000));
      else if (r < 85) rq.offset = {5'd0, 3'($urandom), 32'($urandom)};
      else             rq.offset = {8'($urandom), 32'($urandom)};
      return rq;
   endfunction

   function automatic script_row_type load_row(input int slot, input logic [31:0] start,
                                               input logic [30:0] length,
                                               input logic [39:0] offset);
      script_row_type row;
      row           = '0;
      row.action    = DO_LOAD;
      row.rq.kind   = KIND_LOAD;
      row.rq.slot   = ENTRY_INDEX_W'(slot);
      row.rq.start  = start;
      row.rq.length = length;
      row.rq.offset = offset;
      return row;
   endfunction

   function automatic script_row_type read_row(input logic [31:0] block,
                                               input logic [6:0] count);
      script_row_type row;
      row          = '0;
      row.action   = DO_READ;
      row.rq.kind  = KIND_READ;
      row.rq.block = block;
      row.rq.count = count;
      return row;
   endfunction

   function automatic script_row_type read_typed(input logic [31:0] block,
                                                 input logic [6:0] count, input logic found,
                                                 input logic [40:0] sector,
                                                 input logic [8:0] sectors);
      script_row_type row;
      row       = read_row(block, count);
      row.typed = 1'b1;
      row.want  = '{found: found, sector: sector, sectors: sectors};
      return row;
   endfunction

   function automatic script_row_type csr_row(input logic [6:0] value);
      script_row_type row;
      row           = '0;
      row.action    = DO_CSR;
      row.csr_value = value;
      return row;
   endfunction

   // ---------------------------------------------------------------------------
   // run
   // ---------------------------------------------------------------------------

   initial begin
      int          limit;
      int          target;
      int          r;
      logic [63:0] lo_blk;
      logic [63:0] hi_blk;
      logic [63:0] span;
      request_type rq;
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      req_tuser          = KIND_LOAD;
      rsp_tready         = 1'b0;
      csr_valid          = 1'b0;
      csr_data           = '0;
      mismatch_count     = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      rsp_hold           = 1'b0;
      cached_slot        = 0;
      entry_count_cfg    = 0;
      for (int i = 0; i < DEF_MAX_ENTRIES; i++) begin
         ext_start[i] = '0;
         ext_len[i]   = '0;
         ext_off[i]   = '0;
      end

      script_rows = '{
         // entry_count is zero out of reset: nothing can hit
         read_typed(32'h0, 7'd0, 1'b0, 41'h0, 9'd0),
         read_typed(32'hFFFF_FFFF, 7'd127, 1'b0, 41'h0, 9'd0),
         // small extent at the bottom, a maximal one after it, an empty one,
         // one parked at the top of the offset range, and the last slot
         load_row(0, 32'd1000, 31'd16, 40'd0),
         load_row(1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 40'd16),
         load_row(2, 32'd0, 31'd0, 40'd0),
         load_row(3, 32'h1234_5678, 31'd1, 40'hFF_FFFF_FFFF),
         load_row(63, 32'd0, 31'd0, 40'd0),
         csr_row(7'd4),
         // cached slot 0 holds, then clipping at the end of the extent
         read_typed(32'd0, 7'd1, 1'b1, 41'd1000, 9'd4),
         read_typed(32'd3, 7'd64, 1'b1, 41'd1012, 9'd4),
         // cache miss found by the scan, zero block count
         read_typed(32'd4, 7'd0, 1'b1, 41'h0_FFFF_FFFF, 9'd0),
         // count above the maximum saturates, sector sum carries past 32 bits
         read_typed(32'd5, 7'd127, 1'b1, 41'h1_0000_0003, 9'd256),
         read_typed(32'hFFFF_FFFF, 7'd1, 1'b0, 41'h0, 9'd0),
         // near the far end of the maximal extent
         read_row(32'h1FFF_FFFF, 7'd2),
         read_row(32'h2000_0003, 7'd64),
         // cached slot 1 is no longer below entry_count and must not count
         csr_row(7'd1),
         read_typed(32'd4, 7'd1, 1'b0, 41'h0, 9'd0),
         read_row(32'd2, 7'd1),
         // overlapping extents: cached slot wins, else the lowest slot
         load_row(2, 32'd7000, 31'd8, 40'd0),
         csr_row(7'd4),
         read_row(32'd1, 7'd4),
         read_row(32'd5, 7'd1),
         read_row(32'd0, 7'd3),
         read_row(32'd1, 7'd0)
      };

      // entry_count settings of the random phases, extremes included
      phase_counts = '{64, 127, 1, 37, 0, 64, 12, 100};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // scripted corner cases
      foreach (script_rows[i]) begin
         if (script_rows[i].action == DO_CSR)
            program_entry_count(script_rows[i].csr_value);
         else
            send_request(script_rows[i].rq, script_rows[i].typed, script_rows[i].want);
      end

      // fill the whole table before any wider entry_count, so no read ever
      // touches a slot that was never written
      for (int i = 0; i < DEF_MAX_ENTRIES; i++)
         send_request(random_extent_load(i), 1'b0, '0);

      for (int ph = 0; ph < PHASE_TOTAL; ph++) begin
         program_entry_count(ENTRY_COUNT_W'(phase_counts[ph]));
         // idle pattern rotates: none, sender, receiver, both
         case (ph % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 58;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 58;
            end
            default: begin
               sender_idle_pct    = 33;
               receiver_stall_pct = 33;
            end
         endcase
         limit = (entry_count_cfg < DEF_MAX_ENTRIES) ? entry_count_cfg : DEF_MAX_ENTRIES;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long response hold-off while requests keep coming, so the
            // core backs up and drops req_tready
            if (ph == 0 && n == 10) begin
               fork
                  begin
                     rsp_hold = 1'b1;
                     repeat (HOLD_CYCLES) @(posedge clock);
                     rsp_hold = 1'b0;
                  end
               join_none
            end
            // and once a full stop until every response is back
            if (ph == 0 && n == 60) begin
               req_tvalid = 1'b0;
               while (translations_due.size() != 0) @(negedge clock);
            end
            r = $urandom_range(0, 99);
            if (r < 15) begin
               // rewrite a slot; every slot already holds an extent
               rq = random_extent_load($urandom_range(0, DEF_MAX_ENTRIES - 1));
            end else begin
               rq      = noise_request();
               rq.kind = KIND_READ;
               r = $urandom_range(0, 99);
               if (r < 70)      rq.count = REQ_COUNT_W'($urandom_range(0, 16));
               else if (r < 85) rq.count = REQ_COUNT_W'($urandom_range(0, 64));
               else             rq.count = REQ_COUNT_W'($urandom_range(0, 127));
               // most reads aim inside a live extent, often near its end
               if (limit > 0 && $urandom_range(0, 99) < 75) begin
                  target = $urandom_range(0, limit - 1);
                  lo_blk = (64'(ext_off[target]) + 3) >> 2;
                  hi_blk = (64'(ext_off[target]) + 64'(ext_len[target]) - 1) >> 2;
                  if (ext_len[target] != 0 && lo_blk <= hi_blk && hi_blk <= 64'hFFFF_FFFF) begin
                     span = hi_blk - lo_blk;
                     if ($urandom_range(0, 1) == 1)
                        rq.block = 32'(hi_blk - (64'($urandom_range(0, 20)) % (span + 1)));
                     else
                        rq.block = 32'(lo_blk + ({$urandom, $urandom} % (span + 1)));
                  end
               end else if ($urandom_range(0, 1) == 1) begin
                  rq.block = $urandom_range(0, 12000);
               end
            end
            send_request(rq, 1'b0, '0);
         end
      end

      // drain, then give a stray response time to show up
      req_tvalid = 1'b0;
      while (translations_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("[extent_map_sector_translator_core] OK");
      else
         $display("[extent_map_sector_translator_core] ERROR");
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("[extent_map_sector_translator_core] ERROR");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/emst_pkg.sv
rtl/core/emst_ram.sv
rtl/core/extent_map_sector_translator_core.sv
dv/tb.sv
